### src/sbfp_pkg.sv
// Package for the sync byte frame parser: byte codes, parse phase codes,
// result kinds and the structs shared by the parser modules.
// No dependencies.
`timescale 1ns / 1ps

package sbfp_pkg;

   // Framing bytes.
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] TYPE_FREQ = 8'h46;   // 'F'
   localparam logic [7:0] TYPE_RESP = 8'h52;   // 'R'
   localparam logic [7:0] TYPE_DISC = 8'h44;   // 'D'
   localparam logic [7:0] TYPE_LIST = 8'h4C;   // 'L'

   // Parse phase codes.
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_FREQ = 3'd2;
   localparam logic [2:0] PH_RESP = 3'd3;
   localparam logic [2:0] PH_LCNT = 3'd4;
   localparam logic [2:0] PH_LIDS = 3'd5;

   // Result kinds.
   localparam logic [2:0] KIND_FREQ       = 3'd0;
   localparam logic [2:0] KIND_RESP       = 3'd1;
   localparam logic [2:0] KIND_DISC       = 3'd2;
   localparam logic [2:0] KIND_LIST_ENTRY = 3'd3;
   localparam logic [2:0] KIND_LIST_EMPTY = 3'd4;

   // Payload byte positions inside a frequent data frame.
   localparam logic [2:0] POS_NODE    = 3'd0;
   localparam logic [2:0] POS_LIGHT_L = 3'd1;
   localparam logic [2:0] POS_LIGHT_H = 3'd2;

   // Number of payload bytes in a response frame.
   localparam logic [2:0] RESP_BYTES = 3'd4;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  position;
      logic [31:0] payload;
      logic [7:0]  held_node;
      logic [7:0]  ids_expected;
      logic [7:0]  ids_seen;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  frame_kind;
      logic [7:0]  node_id;
      logic [15:0] light_tenths;
      logic [7:0]  duty;
      logic [31:0] response_value;
      logic [7:0]  list_index;
      logic [7:0]  list_count;
      logic        last_entry;
   } result_type;

endpackage

### src/sbfp_if.sv
// Channel interfaces of the sync byte frame parser: the byte request channel
// and the result channel, each with valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface sbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_kind;
   logic [7:0]  node_id;
   logic [15:0] light_tenths;
   logic [7:0]  duty;
   logic [31:0] response_value;
   logic [7:0]  list_index;
   logic [7:0]  list_count;
   logic        last_entry;

   modport source (output valid, output frame_kind, output node_id, output light_tenths,
                   output duty, output response_value, output list_index,
                   output list_count, output last_entry, input ready);
   modport sink   (input valid, input frame_kind, input node_id, input light_tenths,
                   input duty, input response_value, input list_index,
                   input list_count, input last_entry, output ready);
endinterface

### src/sbfp_step.sv
// Combinational next-state and result logic of the frame parser for one byte.
// Depends on sbfp_pkg.
`timescale 1ns / 1ps

module sbfp_step (
   input  sbfp_pkg::parse_state_type cur_state,
   input  logic [7:0]                rx_byte,
   output sbfp_pkg::parse_state_type nxt_state,
   output sbfp_pkg::result_type      result,
   output logic                      result_valid
);

   logic [2:0] resp_pos;
   logic       list_last;

   assign resp_pos  = cur_state.position + 3'd1;
   assign list_last = ({1'b0, cur_state.ids_seen} + 9'd1) >= {1'b0, cur_state.ids_expected};

   always_comb begin
      nxt_state    = cur_state;
      result       = '0;
      result_valid = 1'b0;
      unique case (cur_state.phase)
         sbfp_pkg::PH_TYPE: begin
            nxt_state.position = '0;
            nxt_state.payload  = '0;
            unique case (rx_byte)
               sbfp_pkg::TYPE_FREQ: nxt_state.phase = sbfp_pkg::PH_FREQ;
               sbfp_pkg::TYPE_RESP: nxt_state.phase = sbfp_pkg::PH_RESP;
               sbfp_pkg::TYPE_LIST: nxt_state.phase = sbfp_pkg::PH_LCNT;
               sbfp_pkg::TYPE_DISC: begin
                  nxt_state.phase   = sbfp_pkg::PH_HUNT;
                  result.frame_kind = sbfp_pkg::KIND_DISC;
                  result_valid      = 1'b1;
               end
               default: nxt_state.phase = sbfp_pkg::PH_HUNT;
            endcase
         end
         sbfp_pkg::PH_FREQ: begin
            unique case (cur_state.position)
               sbfp_pkg::POS_NODE: begin
                  nxt_state.held_node = rx_byte;
                  nxt_state.position  = sbfp_pkg::POS_LIGHT_L;
               end
               sbfp_pkg::POS_LIGHT_L: begin
                  nxt_state.payload  = {24'd0, rx_byte};
                  nxt_state.position = sbfp_pkg::POS_LIGHT_H;
               end
               sbfp_pkg::POS_LIGHT_H: begin
                  nxt_state.payload  = {16'd0, rx_byte, cur_state.payload[7:0]};
                  nxt_state.position = resp_pos;
               end
               default: begin
                  result.frame_kind   = sbfp_pkg::KIND_FREQ;
                  result.node_id      = cur_state.held_node;
                  result.light_tenths = cur_state.payload[15:0];
                  result.duty         = rx_byte;
                  result_valid        = 1'b1;
                  nxt_state.phase     = sbfp_pkg::PH_HUNT;
                  nxt_state.position  = '0;
               end
            endcase
         end
         sbfp_pkg::PH_RESP: begin
            nxt_state.payload  = {cur_state.payload[23:0], rx_byte};
            nxt_state.position = resp_pos;
            if (resp_pos >= sbfp_pkg::RESP_BYTES) begin
               result.frame_kind     = sbfp_pkg::KIND_RESP;
               result.response_value = {cur_state.payload[23:0], rx_byte};
               result_valid          = 1'b1;
               nxt_state.phase       = sbfp_pkg::PH_HUNT;
               nxt_state.position    = '0;
            end
         end
         sbfp_pkg::PH_LCNT: begin
            nxt_state.ids_expected = rx_byte;
            nxt_state.ids_seen     = '0;
            if (rx_byte == 8'd0) begin
               result.frame_kind = sbfp_pkg::KIND_LIST_EMPTY;
               result.last_entry = 1'b1;
               result_valid      = 1'b1;
               nxt_state.phase   = sbfp_pkg::PH_HUNT;
            end else begin
               nxt_state.phase = sbfp_pkg::PH_LIDS;
            end
         end
         sbfp_pkg::PH_LIDS: begin
            result.frame_kind  = sbfp_pkg::KIND_LIST_ENTRY;
            result.node_id     = rx_byte;
            result.list_index  = cur_state.ids_seen;
            result.list_count  = cur_state.ids_expected;
            result.last_entry  = list_last;
            result_valid       = 1'b1;
            nxt_state.ids_seen = cur_state.ids_seen + 8'd1;
            if (list_last) begin
               nxt_state.phase = sbfp_pkg::PH_HUNT;
            end
         end
         default: begin
            // Hunting, and any code that should never occur.
            if (rx_byte == sbfp_pkg::SYNC_BYTE) begin
               nxt_state.phase = sbfp_pkg::PH_TYPE;
            end else begin
               nxt_state.phase = sbfp_pkg::PH_HUNT;
            end
         end
      endcase
   end

endmodule

### src/sync_byte_frame_parser.sv
// Sync byte frame parser: an accepted request is held in the byte input register,
// its result in the result register; one byte request is taken every cycle while
// the result side keeps up. Rate is set by the single parse step between the
// byte input register and the result register. Synchronous active-high reset
// returns the parser to hunting and empties both registers.
// Depends on sbfp_pkg, sbfp_if and sbfp_step.
`timescale 1ns / 1ps

module sync_byte_frame_parser (
   input  logic             clock,
   input  logic             reset,
   sbfp_req_if.sink         req_chan,
   sbfp_rsp_if.source       rsp_chan
);

   // The byte input register holds one accepted request. It is processed as
   // soon as the result register can take what it may produce; a byte that
   // produces no result is simply consumed.
   logic                      byte_valid_ff;
   logic                      byte_valid_in;
   logic [7:0]                byte_ff;

   // Parser state, advanced once per processed byte.
   sbfp_pkg::parse_state_type state_ff;
   sbfp_pkg::parse_state_type state_in;

   // Result register that feeds the rsp channel.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sbfp_pkg::result_type      rsp_ff;

   sbfp_pkg::result_type      step_result;
   logic                      step_valid;
   logic                      advance;
   logic                      req_accept;

   // A byte moves through the parse step when the result register is empty or
   // is being emptied this cycle. The result register therefore separates the
   // two sides so that a new request is taken while a finished result waits.
   assign advance    = byte_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !byte_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   sbfp_step u_step (
      .cur_state    (state_ff),
      .rx_byte      (byte_ff),
      .nxt_state    (state_in),
      .result       (step_result),
      .result_valid (step_valid)
   );

   assign byte_valid_in = req_accept || (byte_valid_ff && !advance);

   always_comb begin
      if (advance && step_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{phase: sbfp_pkg::PH_HUNT, default: '0};
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset; they are qualified by their valid bits.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_chan.rx_byte;
      end
      if (advance && step_valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.frame_kind     = rsp_ff.frame_kind;
   assign rsp_chan.node_id        = rsp_ff.node_id;
   assign rsp_chan.light_tenths   = rsp_ff.light_tenths;
   assign rsp_chan.duty           = rsp_ff.duty;
   assign rsp_chan.response_value = rsp_ff.response_value;
   assign rsp_chan.list_index     = rsp_ff.list_index;
   assign rsp_chan.list_count     = rsp_ff.list_count;
   assign rsp_chan.last_entry     = rsp_ff.last_entry;

endmodule

### src/sbfp_checker.sv
// Port-level checker for the sync byte frame parser and its bind statement.
// Depends on sbfp_pkg, sbfp_if and sync_byte_frame_parser.
`timescale 1ns / 1ps

module sbfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_frame_kind,
   input logic [7:0]  rsp_list_index,
   input logic [7:0]  rsp_list_count,
   input logic        rsp_last_entry,
   input logic [31:0] rsp_response_value
);

   // No result may appear right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result holds its kind.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_kind))
      else $error("stalled result changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_kind <= sbfp_pkg::KIND_LIST_EMPTY)
      else $error("result kind out of range");

   // List entries sit inside the announced count; the last one is at its end.
   a_list_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind == sbfp_pkg::KIND_LIST_ENTRY |->
         rsp_list_index < rsp_list_count &&
         (rsp_last_entry == ({1'b0, rsp_list_index} + 9'd1 >= {1'b0, rsp_list_count})))
      else $error("list entry index inconsistent");

   // Frequent data and discovery results are never marked last and carry no word.
   a_field_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind == sbfp_pkg::KIND_FREQ ||
                    rsp_frame_kind == sbfp_pkg::KIND_DISC) |->
         !rsp_last_entry && rsp_response_value == 32'd0)
      else $error("unrelated fields set on result");

endmodule

bind sync_byte_frame_parser sbfp_checker u_sbfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_frame_kind     (rsp_chan.frame_kind),
   .rsp_list_index     (rsp_chan.list_index),
   .rsp_list_count     (rsp_chan.list_count),
   .rsp_last_entry     (rsp_chan.last_entry),
   .rsp_response_value (rsp_chan.response_value)
);

### test/tb_sync_byte_frame_parser.sv
// Self-checking testbench for sync_byte_frame_parser: a directed table of byte
// requests followed by random framed traffic, checked against a built-in parser.
// Depends on sbfp_pkg, sbfp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_sync_byte_frame_parser;

   // One row of the directed table. When exp_given is set, the result that the
   // byte completes is typed in here rather than taken from the parser model.
   typedef struct packed {
      logic [7:0]           rx_byte;
      logic                 exp_given;
      sbfp_pkg::result_type exp_result;
   } byte_row_type;

   localparam sbfp_pkg::result_type NO_RESULT = '0;
   localparam int         N_DIRECTED = 26;
   localparam int         PHASE_REQUESTS = 85;

   // The directed table walks the special cases in order: a stray byte while
   // hunting, an unknown type, a second sync byte taken as an unknown type,
   // discovery, frequent data and a response with every payload byte at the
   // sync value or at a readable pattern, an empty node list, and a list of one.
   localparam byte_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'h00, 1'b0, NO_RESULT},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::TYPE_DISC, 1'b1, '{frame_kind: sbfp_pkg::KIND_DISC, default: '0}},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::TYPE_FREQ, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, '{frame_kind: sbfp_pkg::KIND_FREQ, node_id: 8'hFF,
                       light_tenths: 16'hFFFF, duty: 8'hFF, default: '0}},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::TYPE_RESP, 1'b0, NO_RESULT},
      '{8'h12, 1'b0, NO_RESULT},
      '{8'h34, 1'b0, NO_RESULT},
      '{8'h56, 1'b0, NO_RESULT},
      '{8'h78, 1'b1, '{frame_kind: sbfp_pkg::KIND_RESP, response_value: 32'h12345678,
                       default: '0}},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::TYPE_LIST, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{frame_kind: sbfp_pkg::KIND_LIST_EMPTY, last_entry: 1'b1,
                       default: '0}},
      '{sbfp_pkg::SYNC_BYTE, 1'b0, NO_RESULT},
      '{sbfp_pkg::TYPE_LIST, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT}
   };

   // Sender idle and receiver stall chances, in percent, for each random phase.
   localparam int IDLE_PCT [4]  = '{0, 70, 0, 20};
   localparam int STALL_PCT [4] = '{0, 0, 70, 20};

   logic clock = 1'b0;
   logic reset;

   sbfp_req_if req_chan ();
   sbfp_rsp_if rsp_chan ();

   sync_byte_frame_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run ends here if the parser stops answering.
   initial begin
      #2_000_000;
      $display("tb_sync_byte_frame_parser: errors");
      $finish;
   end

   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int request_count = 0;

   // Results that the accepted byte requests have caused and that the result
   // channel still owes, oldest first.
   sbfp_pkg::result_type results_due[$];

   // The typed-in expectation that travels with the request being driven.
   logic                 req_exp_given = 1'b0;
   sbfp_pkg::result_type req_exp_result = '0;

   // Parser state as the testbench sees it.
   logic [2:0]  frame_phase = sbfp_pkg::PH_HUNT;
   logic [2:0]  frame_pos = '0;
   logic [31:0] frame_word = '0;
   logic [7:0]  frame_node = '0;
   logic [7:0]  list_len = '0;
   logic [7:0]  list_taken = '0;

   // Advances the parser state by one received byte and reports the result
   // that this byte completes, if any. Fields that do not belong to the
   // result kind stay zero.
   task automatic parse_rx_byte(input logic [7:0] b, output bit emits,
                                output sbfp_pkg::result_type res);
      logic last;
      emits = 1'b0;
      res = '0;
      case (frame_phase)
         sbfp_pkg::PH_TYPE: begin
            frame_pos = '0;
            frame_word = '0;
            if (b == sbfp_pkg::TYPE_FREQ) begin
               frame_phase = sbfp_pkg::PH_FREQ;
            end else if (b == sbfp_pkg::TYPE_RESP) begin
               frame_phase = sbfp_pkg::PH_RESP;
            end else if (b == sbfp_pkg::TYPE_LIST) begin
               frame_phase = sbfp_pkg::PH_LCNT;
            end else begin
               // Discovery is reported on its type byte; any other type,
               // the sync value included, is simply dropped.
               frame_phase = sbfp_pkg::PH_HUNT;
               if (b == sbfp_pkg::TYPE_DISC) begin
                  emits = 1'b1;
                  res.frame_kind = sbfp_pkg::KIND_DISC;
               end
            end
         end
         sbfp_pkg::PH_FREQ: begin
            case (frame_pos)
               sbfp_pkg::POS_NODE: begin
                  frame_node = b;
                  frame_pos = sbfp_pkg::POS_LIGHT_L;
               end
               sbfp_pkg::POS_LIGHT_L: begin
                  frame_word = {24'h0, b};
                  frame_pos = sbfp_pkg::POS_LIGHT_H;
               end
               sbfp_pkg::POS_LIGHT_H: begin
                  frame_word[15:8] = b;
                  frame_pos = frame_pos + 3'd1;
               end
               default: begin
                  emits = 1'b1;
                  res.frame_kind = sbfp_pkg::KIND_FREQ;
                  res.node_id = frame_node;
                  res.light_tenths = frame_word[15:0];
                  res.duty = b;
                  frame_phase = sbfp_pkg::PH_HUNT;
                  frame_pos = '0;
               end
            endcase
         end
         sbfp_pkg::PH_RESP: begin
            // The response word arrives most significant byte first.
            frame_word = {frame_word[23:0], b};
            frame_pos = frame_pos + 3'd1;
            if (frame_pos >= sbfp_pkg::RESP_BYTES) begin
               emits = 1'b1;
               res.frame_kind = sbfp_pkg::KIND_RESP;
               res.response_value = frame_word;
               frame_phase = sbfp_pkg::PH_HUNT;
               frame_pos = '0;
            end
         end
         sbfp_pkg::PH_LCNT: begin
            list_len = b;
            list_taken = '0;
            if (b == 8'h00) begin
               emits = 1'b1;
               res.frame_kind = sbfp_pkg::KIND_LIST_EMPTY;
               res.last_entry = 1'b1;
               frame_phase = sbfp_pkg::PH_HUNT;
            end else begin
               frame_phase = sbfp_pkg::PH_LIDS;
            end
         end
         sbfp_pkg::PH_LIDS: begin
            last = ({1'b0, list_taken} + 9'd1) >= {1'b0, list_len};
            emits = 1'b1;
            res.frame_kind = sbfp_pkg::KIND_LIST_ENTRY;
            res.node_id = b;
            res.list_index = list_taken;
            res.list_count = list_len;
            res.last_entry = last;
            list_taken = list_taken + 8'd1;
            if (last) begin
               frame_phase = sbfp_pkg::PH_HUNT;
            end
         end
         default: begin
            // While hunting only the sync byte moves the parser on.
            frame_phase = (b == sbfp_pkg::SYNC_BYTE) ? sbfp_pkg::PH_TYPE : sbfp_pkg::PH_HUNT;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Both channels are observed at the rising edge, where the values driven at
   // the falling edge before it are settled. Each accepted byte request
   // advances the parser state; each accepted result is checked against the
   // oldest one that is owed.
   always @(posedge clock) begin
      bit                   emits;
      sbfp_pkg::result_type predicted;
      sbfp_pkg::result_type seen;
      sbfp_pkg::result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            parse_rx_byte(req_chan.rx_byte, emits, predicted);
            if (req_exp_given) begin
               results_due = {results_due, req_exp_result};
            end else if (emits) begin
               results_due = {results_due, predicted};
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{rsp_chan.frame_kind, rsp_chan.node_id, rsp_chan.light_tenths,
                     rsp_chan.duty, rsp_chan.response_value, rsp_chan.list_index,
                     rsp_chan.list_count, rsp_chan.last_entry};
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0h", $time, seen);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               check_field("frame_kind", want.frame_kind, seen.frame_kind);
               check_field("node_id", want.node_id, seen.node_id);
               check_field("light_tenths", want.light_tenths, seen.light_tenths);
               check_field("duty", want.duty, seen.duty);
               check_field("response_value", want.response_value, seen.response_value);
               check_field("list_index", want.list_index, seen.list_index);
               check_field("list_count", want.list_count, seen.list_count);
               check_field("last_entry", want.last_entry, seen.last_entry);
            end
         end
      end
   end

   // The result side stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Drives one byte request from a falling edge and returns at the falling
   // edge after it has been accepted. Random idle cycles go in front of it.
   task automatic send_byte(input logic [7:0] value, input logic exp_given = 1'b0,
                            input sbfp_pkg::result_type exp_result = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= value;
      req_exp_given <= exp_given;
      req_exp_result <= exp_result;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Payload bytes lean toward the sync value and zero so that both reach
   // every field often.
   function automatic logic [7:0] payload_byte();
      case ($urandom_range(7))
         0: return sbfp_pkg::SYNC_BYTE;
         1: return 8'h00;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Sends one random piece of traffic: mostly well-formed frames with random
   // content, sometimes a sync byte with an unknown type, and sometimes stray
   // bytes while hunting, which are not counted since the parser skips them.
   task automatic send_random_frame();
      int         pick;
      int         n;
      logic [7:0] kind;
      logic [7:0] count;
      pick = $urandom_range(99);
      if (pick < 10) begin
         n = $urandom_range(3, 1);
         repeat (n) send_byte(8'($urandom_range(254)));
      end else if (pick < 20) begin
         do kind = payload_byte();
         while (kind inside {sbfp_pkg::TYPE_FREQ, sbfp_pkg::TYPE_RESP,
                             sbfp_pkg::TYPE_DISC, sbfp_pkg::TYPE_LIST});
         send_byte(sbfp_pkg::SYNC_BYTE);
         send_byte(kind);
         request_count += 2;
      end else begin
         send_byte(sbfp_pkg::SYNC_BYTE);
         case ($urandom_range(3))
            0: begin
               send_byte(sbfp_pkg::TYPE_FREQ);
               repeat (4) send_byte(payload_byte());
               request_count += 6;
            end
            1: begin
               send_byte(sbfp_pkg::TYPE_RESP);
               repeat (4) send_byte(payload_byte());
               request_count += 6;
            end
            2: begin
               send_byte(sbfp_pkg::TYPE_DISC);
               request_count += 2;
            end
            default: begin
               count = 8'($urandom_range(6));
               send_byte(sbfp_pkg::TYPE_LIST);
               send_byte(count);
               repeat (count) send_byte(payload_byte());
               request_count += 3 + count;
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, with both sides running flat out.
      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].exp_given,
                   DIRECTED_ROWS[i].exp_result);
      end

      for (int ph = 0; ph < 4; ph++) begin
         // Hold the sender off until every owed result has come back, so
         // that the next phase starts from an empty pipeline.
         req_chan.valid <= 1'b0;
         while (results_due.size() != 0) @(negedge clock);
         idle_pct = IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         request_count = 0;

         // The longest node list runs once, under sender idling, to reach
         // the top list index and count.
         if (ph == 1) begin
            send_byte(sbfp_pkg::SYNC_BYTE);
            send_byte(sbfp_pkg::TYPE_LIST);
            send_byte(8'hFF);
            repeat (255) send_byte(payload_byte());
         end

         while (request_count < PHASE_REQUESTS) send_random_frame();
      end

      req_chan.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && results_due.size() == 0) begin
         $display("tb_sync_byte_frame_parser: clean");
      end else begin
         $display("tb_sync_byte_frame_parser: errors");
      end
      $finish;
   end

endmodule
